// ----- sv/msap_pkg.sv -----
// ----------------------------------------------------------------------------
// msap_pkg
// shared widths, limits and sideband types for the partition max-sum block
// ----------------------------------------------------------------------------
package msap_pkg;

  localparam int VALUE_W       = 16;
  localparam int TOTAL_W       = 48;
  localparam int CFG_W         = 5;
  localparam int SUM_W         = 50;
  localparam int K_MAX_DEFAULT = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 48'sh8000_0000_0000;

  // read issue toward the memories
  typedef struct packed {
    logic valid;
    logic zero_pb;
  } rd_req_t;

  // tag that comes back with the registered read data
  typedef struct packed {
    logic valid;
    logic first;
    logic zero_pb;
  } rd_tag_t;

endpackage

// ----- sv/msap_store.sv -----
// ----------------------------------------------------------------------------
// msap_store
// circular value and prefix-best memories, one write and one registered read
// port each
// ----------------------------------------------------------------------------
module msap_store #(
  parameter int AW = 4,
  parameter int LW = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vwr_en,
  input  logic [AW-1:0]                       vwr_addr,
  input  logic signed [msap_pkg::VALUE_W-1:0] vwr_data,
  input  logic                                pwr_en,
  input  logic [AW-1:0]                       pwr_addr,
  input  logic signed [msap_pkg::TOTAL_W-1:0] pwr_data,
  input  msap_pkg::rd_req_t                   rd_req,
  input  logic [AW-1:0]                       rd_vaddr,
  input  logic [AW-1:0]                       rd_paddr,
  input  logic [LW-1:0]                       rd_l,
  output msap_pkg::rd_tag_t                   rd_tag,
  output logic [LW-1:0]                       rd_l_q,
  output logic signed [msap_pkg::VALUE_W-1:0] rd_value,
  output logic signed [msap_pkg::TOTAL_W-1:0] rd_pb
);

  localparam int DEPTH = 1 << AW;

  logic signed [msap_pkg::VALUE_W-1:0] vmem [DEPTH];
  logic signed [msap_pkg::TOTAL_W-1:0] pmem [DEPTH];

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vmem[vwr_addr] <= vwr_data;
    end
    if (pwr_en) begin
      pmem[pwr_addr] <= pwr_data;
    end
    rd_value <= vmem[rd_vaddr];
    rd_pb    <= pmem[rd_paddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= rd_req.valid;
    end
    rd_tag.first   <= (rd_l == LW'(1));
    rd_tag.zero_pb <= rd_req.zero_pb;
    rd_l_q         <= rd_l;
  end

endmodule

// ----- sv/msap_eval.sv -----
// ----------------------------------------------------------------------------
// msap_eval
// running window maximum, group product and best-candidate compare
// ----------------------------------------------------------------------------
module msap_eval #(
  parameter int LW = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  msap_pkg::rd_tag_t                   rd_tag,
  input  logic [LW-1:0]                       rd_l,
  input  logic signed [msap_pkg::VALUE_W-1:0] rd_value,
  input  logic signed [msap_pkg::TOTAL_W-1:0] rd_pb,
  output logic                                busy,
  output logic signed [msap_pkg::SUM_W-1:0]   best
);

  logic signed [msap_pkg::VALUE_W-1:0] run_max;
  logic signed [msap_pkg::VALUE_W-1:0] new_max;
  logic                                s2_valid;
  logic                                s2_first;
  logic signed [LW+16:0]               prod;
  logic signed [msap_pkg::TOTAL_W-1:0] pb;
  logic signed [msap_pkg::SUM_W-1:0]   cand;

  assign new_max = (rd_tag.first || (rd_value > run_max)) ? rd_value : run_max;
  assign cand    = msap_pkg::SUM_W'(pb) + msap_pkg::SUM_W'(prod);
  assign busy    = rd_tag.valid || s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= rd_tag.valid;
    end
    if (rd_tag.valid) begin
      run_max  <= new_max;
      prod     <= $signed({1'b0, rd_l}) * new_max;
      pb       <= rd_tag.zero_pb ? '0 : rd_pb;
      s2_first <= rd_tag.first;
    end
    if (s2_valid) begin
      if (s2_first || (cand > best)) begin
        best <= cand;
      end
    end
  end

endmodule

// ----- sv/max_sum_after_partitioning_top.sv -----
// ----------------------------------------------------------------------------
// max_sum_after_partitioning_top
// flow: per accepted request, lim = min(k, count) candidate group lengths are
//   read through the single memory read port, the evaluation pipeline drains,
//   then the result loads; no new request is taken until the result is loaded
// reset: synchronous, clears the sequencer, counts and output valid; k = 3
// streaming best partition sum with groups of at most k elements
// ----------------------------------------------------------------------------
module max_sum_after_partitioning_top #(
  parameter int K_MAX = msap_pkg::K_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [msap_pkg::VALUE_W-1:0] value,
  input  logic                                last_element,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msap_pkg::TOTAL_W-1:0] best_total,
  output logic                                saturated,
  output logic                                array_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msap_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int LW = $clog2(K_MAX + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                  state;
  logic [msap_pkg::CFG_W-1:0]  cfg_k;
  logic [AW-1:0]               wp;
  logic [LW-1:0]               seen;
  logic [LW-1:0]               lim;
  logic [LW-1:0]               j;
  logic                        last_q;

  logic                        in_acc;
  logic                        fin_go;
  logic [LW-1:0]               k_eff;
  logic [LW:0]                 seen_p1;
  logic [LW-1:0]               lim_next;

  msap_pkg::rd_req_t           rd_req;
  msap_pkg::rd_tag_t           rd_tag;
  logic [AW-1:0]               rd_vaddr;
  logic [AW-1:0]               rd_paddr;
  logic [LW-1:0]               rd_l;
  logic [LW-1:0]               rd_l_q;
  logic signed [msap_pkg::VALUE_W-1:0] rd_value;
  logic signed [msap_pkg::TOTAL_W-1:0] rd_pb;
  logic                        eval_busy;
  logic signed [msap_pkg::SUM_W-1:0]   best_sum;
  logic signed [msap_pkg::TOTAL_W-1:0] best_clamp;
  logic                        sat_now;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign fin_go    = (state == ST_FIN) && (!out_valid || !out_stall);

  // effective group length and step count
  always_comb begin
    if (cfg_k == '0) begin
      k_eff = LW'(1);
    end else if (int'(cfg_k) > K_MAX) begin
      k_eff = LW'(K_MAX);
    end else begin
      k_eff = LW'(cfg_k);
    end
    seen_p1 = {1'b0, seen} + 1'b1;
    if (seen_p1 > {1'b0, k_eff}) begin
      lim_next = k_eff;
    end else begin
      lim_next = seen_p1[LW-1:0];
    end
  end

  assign rd_req.valid   = (state == ST_RUN);
  assign rd_req.zero_pb = (j == seen);
  assign rd_vaddr       = wp - AW'(j);
  assign rd_paddr       = wp - AW'(j) - 1'b1;
  assign rd_l           = j + 1'b1;

  always_comb begin
    if (best_sum > msap_pkg::SUM_W'(msap_pkg::TOTAL_MAX)) begin
      best_clamp = msap_pkg::TOTAL_MAX;
      sat_now    = 1'b1;
    end else if (best_sum < msap_pkg::SUM_W'(msap_pkg::TOTAL_MIN)) begin
      best_clamp = msap_pkg::TOTAL_MIN;
      sat_now    = 1'b1;
    end else begin
      best_clamp = best_sum[msap_pkg::TOTAL_W-1:0];
      sat_now    = 1'b0;
    end
  end

  msap_store #(
    .AW(AW),
    .LW(LW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .vwr_en   (in_acc),
    .vwr_addr (wp),
    .vwr_data (value),
    .pwr_en   (fin_go),
    .pwr_addr (wp),
    .pwr_data (best_clamp),
    .rd_req   (rd_req),
    .rd_vaddr (rd_vaddr),
    .rd_paddr (rd_paddr),
    .rd_l     (rd_l),
    .rd_tag   (rd_tag),
    .rd_l_q   (rd_l_q),
    .rd_value (rd_value),
    .rd_pb    (rd_pb)
  );

  msap_eval #(
    .LW(LW)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .rd_tag   (rd_tag),
    .rd_l     (rd_l_q),
    .rd_value (rd_value),
    .rd_pb    (rd_pb),
    .busy     (eval_busy),
    .best     (best_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cfg_k     <= msap_pkg::CFG_RESET;
      wp        <= '0;
      seen      <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_k <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            lim    <= lim_next;
            last_q <= last_element;
            j      <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (j == lim - 1'b1) begin
            state <= ST_WAIT;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_WAIT: begin
          if (!eval_busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            wp <= wp + 1'b1;
            if (last_q) begin
              seen <= '0;
            end else if (seen != LW'(K_MAX)) begin
              seen <= seen + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      best_total <= best_clamp;
      saturated  <= sat_now;
      array_done <= last_q;
    end
  end

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> out_valid)
    else $error("result not loaded after final step");

  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    int'(seen) <= K_MAX)
    else $error("element count above window depth");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (j < lim))
    else $error("read issued past step count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (fin_go && last_q) |=> (seen == '0))
    else $error("array state not cleared at end of array");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !eval_busy)
    else $error("evaluation pipeline active while idle");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives array elements through the partition max-sum block and checks every
// prefix total against a cycle-free predictor kept alongside, over several
// group-length settings, random idling on both sides and one long output hold
// ----------------------------------------------------------------------------
module testbench;

  localparam int K_MAX = msap_pkg::K_MAX_DEFAULT;
  localparam longint SUM_HI = longint'(msap_pkg::TOTAL_MAX);
  localparam longint SUM_LO = longint'(msap_pkg::TOTAL_MIN);
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [msap_pkg::VALUE_W-1:0] value;
    logic                                last;
  } array_elem_t;

  typedef struct packed {
    logic signed [msap_pkg::TOTAL_W-1:0] total;
    logic                                sat;
    logic                                done;
  } total_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [msap_pkg::VALUE_W-1:0] value = '0;
  logic                                last_element = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [msap_pkg::TOTAL_W-1:0] best_total;
  logic                                saturated;
  logic                                array_done;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [msap_pkg::CFG_W-1:0]          cfg_data = '0;

  // predictor state
  logic signed [msap_pkg::VALUE_W-1:0] window_vals [K_MAX];
  logic signed [msap_pkg::TOTAL_W-1:0] prefix_totals [K_MAX];
  int unsigned                         seen_vals;
  logic [msap_pkg::CFG_W-1:0]          group_len = msap_pkg::CFG_RESET;

  array_elem_t   pending_elems[$];
  total_result_t expected_totals[$];
  array_elem_t   next_elem;
  total_result_t got;
  total_result_t want;

  logic sender_idles = 1'b0;
  logic receiver_idles = 1'b0;
  logic hold_off_arm = 1'b0;
  int   hold_left;
  int   send_gap;
  int   recv_wait;
  int   elems_queued;
  int   requests_taken;
  int   results_seen;
  int   arrays_closed;
  int   settings_used;
  int   mismatch_count;
  int   run_left;

  max_sum_after_partitioning_top #(
    .K_MAX(K_MAX)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .last_element(last_element),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .best_total  (best_total),
    .saturated   (saturated),
    .array_done  (array_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_array();
    int j;
    for (j = 0; j < K_MAX; j++) begin
      window_vals[j] = '0;
      prefix_totals[j] = '0;
    end
    seen_vals = 0;
  endfunction

  function automatic total_result_t fold_in_value(
    input logic signed [msap_pkg::VALUE_W-1:0] v,
    input logic                                last
  );
    total_result_t r;
    int unsigned k;
    int unsigned lim;
    int unsigned l;
    int j;
    longint peak;
    longint best;
    longint cand;
    k = 32'(group_len);
    if (k < 1) k = 1;
    if (k > K_MAX) k = K_MAX;
    lim = (seen_vals + 1 > k) ? k : seen_vals + 1;
    for (j = K_MAX - 1; j > 0; j--) window_vals[j] = window_vals[j-1];
    window_vals[0] = v;
    peak = longint'(window_vals[0]);
    best = longint'(prefix_totals[0]) + peak;
    for (l = 2; l <= lim; l++) begin
      if (longint'(window_vals[l-1]) > peak) peak = longint'(window_vals[l-1]);
      cand = longint'(prefix_totals[l-1]) + longint'(l) * peak;
      if (cand > best) best = cand;
    end
    r.sat = 1'b0;
    if (best > SUM_HI) begin
      best = SUM_HI;
      r.sat = 1'b1;
    end else if (best < SUM_LO) begin
      best = SUM_LO;
      r.sat = 1'b1;
    end
    for (j = K_MAX - 1; j > 0; j--) prefix_totals[j] = prefix_totals[j-1];
    prefix_totals[0] = best[msap_pkg::TOTAL_W-1:0];
    if (seen_vals < K_MAX) seen_vals++;
    r.total = best[msap_pkg::TOTAL_W-1:0];
    r.done = last;
    if (last) clear_array();
    return r;
  endfunction

  // request driver, also tracks accepted register writes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cfg_valid && cfg_ready) group_len = cfg_data;
      if (in_valid && !in_stall) begin
        expected_totals.push_back(fold_in_value(value, last_element));
        requests_taken++;
        send_gap = sender_idles ? $urandom_range(0, 4) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_elems.size() != 0) begin
          next_elem = pending_elems.pop_front();
          in_valid <= 1'b1;
          value <= next_elem.value;
          last_element <= next_elem.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_off_arm) begin
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got.total = best_total;
        got.sat = saturated;
        got.done = array_done;
        if (expected_totals.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: result %h/%b/%b with nothing expected",
                     got.total, got.sat, got.done);
        end else begin
          want = expected_totals.pop_front();
          if (got.total !== want.total || got.sat !== want.sat || got.done !== want.done)
          begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: result %0d total exp %0d got %0d",
                        " sat exp %b got %b done exp %b got %b"},
                       results_seen, want.total, got.total, want.sat, got.sat,
                       want.done, got.done);
          end
          if (want.done) arrays_closed++;
        end
        recv_wait = receiver_idles ? $urandom_range(0, 4) : 0;
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0) || (hold_left != 0);
    end
  end

  task automatic queue_elem(input logic signed [msap_pkg::VALUE_W-1:0] v, input logic last);
    array_elem_t e;
    e.value = v;
    e.last = last;
    pending_elems.push_back(e);
    elems_queued++;
  endtask

  task automatic queue_random(input int count);
    logic signed [msap_pkg::VALUE_W-1:0] v;
    int n;
    for (n = 0; n < count; n++) begin
      if (run_left == 0)
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0: v = 16'sh7FFF;
        1: v = 16'sh8000;
        2: v = 16'($signed($urandom_range(0, 16)) - 8);
        default: v = 16'($urandom_range(0, 65535));
      endcase
      queue_elem(v, run_left == 1);
      run_left--;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (requests_taken != elems_queued || results_seen < requests_taken ||
           expected_totals.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_group_len(input logic [msap_pkg::CFG_W-1:0] k);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : sequencer
    logic [msap_pkg::CFG_W-1:0] phase_k [8];
    int p;
    clear_array();
    phase_k = '{5'd17, 5'd16, 5'd1, 5'd2, 5'd5, 5'd8, 5'd0, 5'd0};
    phase_k[6] = 5'($urandom_range(0, 31));
    phase_k[7] = 5'($urandom_range(0, 31));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset group length of three
    @(negedge clk);
    queue_elem(16'sh7FFF, 1'b1);
    queue_elem(16'sh8000, 1'b1);
    queue_elem(16'sd0, 1'b0);
    queue_elem(-16'sd1, 1'b0);
    queue_elem(16'sh7FFF, 1'b0);
    queue_elem(16'sh8000, 1'b0);
    queue_elem(16'sd1, 1'b1);
    queue_elem(16'sd1, 1'b0);
    queue_elem(16'sd15, 1'b0);
    queue_elem(16'sd7, 1'b0);
    queue_elem(16'sd9, 1'b0);
    queue_elem(16'sd2, 1'b0);
    queue_elem(16'sd5, 1'b0);
    queue_elem(16'sd10, 1'b1);
    wait_drained();

    // zero group length behaves as one
    set_group_len(5'd0);
    @(negedge clk);
    queue_elem(16'sh8000, 1'b0);
    queue_elem(16'sh7FFF, 1'b0);
    queue_elem(16'sd5, 1'b1);
    wait_drained();

    // oversized group length, array left open across the next write
    set_group_len(5'd31);
    @(negedge clk);
    queue_elem(16'sh7FFF, 1'b0);
    queue_elem(16'sh8000, 1'b0);
    queue_elem(16'sh7FFF, 1'b0);
    queue_elem(16'sh8000, 1'b0);
    queue_elem(16'sd100, 1'b0);
    queue_elem(-16'sd5, 1'b0);
    queue_elem(16'sh7FFF, 1'b0);
    queue_elem(-16'sd1, 1'b0);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      set_group_len(phase_k[p]);
      sender_idles <= (p % 3) != 0;
      receiver_idles <= (p % 4) != 1;
      if (p == 2) begin
        @(posedge clk);
        hold_off_arm <= 1'b1;
        @(posedge clk);
        hold_off_arm <= 1'b0;
      end
      @(negedge clk);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (expected_totals.size() != 0) mismatch_count++;
    $display("summary: %0d requests, %0d arrays closed, %0d group-length writes",
             requests_taken, arrays_closed, settings_used);
    $display("summary: %0d results compared, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d of %0d requests, %0d results", requests_taken, elems_queued,
             results_seen);
    $display("testbench: errors");
    $finish;
  end

endmodule

// ----- max_sum_after_partitioning_top.f -----
sv/msap_pkg.sv
sv/msap_store.sv
sv/msap_eval.sv
sv/max_sum_after_partitioning_top.sv
tb/sv/testbench.sv
